// ===== src/dfs_pkg.sv =====
package dfs_pkg;

	localparam int DEF_ELEM_WIDTH  = 32;
	localparam int DEF_STACK_DEPTH = 1024;
	localparam int DEF_FRAME_DEPTH = 256;

	localparam int KIND_W   = 4;
	localparam int ELEM_W   = 32;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int SAVED_W  = 9;
	localparam int ITEMS_W  = 11;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 72;
	localparam int M_USER_W = 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH       = 4'd0,
		KIND_POP        = 4'd1,
		KIND_TOP        = 4'd2,
		KIND_BOTTOM     = 4'd3,
		KIND_POP_BOTTOM = 4'd4,
		KIND_ENTER      = 4'd5,
		KIND_LEAVE      = 4'd6,
		KIND_CLEAR      = 4'd7,
		KIND_DISCARD    = 4'd8
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_NOFRAME = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		ALU_SUB = 1'b0,
		ALU_ADD = 1'b1
	} alu_op_t;

endpackage

// ===== src/dfs_ram.sv =====
module dfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/dfs_alu.sv =====
module dfs_alu
	import dfs_pkg::*;
#(
	parameter int W = 11
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         borrow
);

	logic [W:0] full;

	always_comb begin
		if (op == ALU_ADD) begin
			full = {1'b0, a} + {1'b0, b};
		end else begin
			full = {1'b0, a} - {1'b0, b};
		end
	end

	assign res    = full[W-1:0];
	assign borrow = (op == ALU_SUB) && full[W];

endmodule

// ===== src/dfs_frame_stack_core.sv =====
// channel  dir  tdata                                   tuser
// s        in   element[31:0] count[42:32]             kind[3:0]
// m        out  element_out[31:0] status[33:32]        found[0]
//               frames_saved[42:34] frame_items[53:43]
//               total_items[64:54]
//
// Ops run S_AVAIL, S_OP, S_FIN; pop/top add S_RD, bottom reads S_BADDR and S_RD; leave adds
// S_LEAVE, S_LVRD. Discard skips S_OP: S_DCMP, then S_DSUB, S_LEAVE, S_LVRD, S_AVAIL per frame left,
// then S_DDROP, S_DSIZE. Most arithmetic goes through the single add/sub unit, one use per cycle.
// arst_n clears counters and control; store contents stay undefined.
// s_tready is low while an op runs; a finished op waits in its last state
// until the result register is free.
module dfs_frame_stack_core
	import dfs_pkg::*;
#(
	parameter int ELEM_WIDTH  = DEF_ELEM_WIDTH,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int FRAME_DEPTH = DEF_FRAME_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // element, count
	input  logic [KIND_W-1:0]   s_tuser,  // kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // element_out, status, frames_saved,
	                                      // frame_items, total_items
	output logic [M_USER_W-1:0] m_tuser   // found
);

	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int SW  = $clog2(FRAME_DEPTH + 1);
	localparam int EAW = $clog2(STACK_DEPTH);
	localparam int FAW = $clog2(FRAME_DEPTH);
	localparam int W0  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int W   = (W0 > SW) ? W0 : SW;
	localparam int PAD = M_DATA_W - ELEM_W - STATUS_W - SAVED_W - 2 * ITEMS_W;

	typedef enum logic [3:0] {
		S_IDLE, S_AVAIL, S_OP, S_BADDR, S_RD, S_LEAVE, S_LVRD,
		S_DCMP, S_DSUB, S_DDROP, S_DSIZE, S_FIN
	} state_t;

	state_t                state_q;
	kind_t                 kind_q;
	status_t               status_q;
	logic [ELEM_WIDTH-1:0] elem_q;
	logic [ELEM_WIDTH-1:0] eout_q;
	logic                  found_q;
	logic [W-1:0]          num_q;
	logic [W-1:0]          avail_q;
	logic [W-1:0]          tmp_q;
	logic                  empty_q;
	logic                  skip_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         size_q;
	logic [CW-1:0]         bot_q;
	logic [SW-1:0]         saved_q;

	alu_op_t               alu_op;
	logic [W-1:0]          alu_a;
	logic [W-1:0]          alu_b;
	logic [W-1:0]          alu_res;
	logic                  alu_borrow;
	logic [W-1:0]          alu_sat;

	logic                  e_we;
	logic [ELEM_WIDTH-1:0] e_rdata;
	logic                  f_we;
	logic [2*CW-1:0]       f_rdata;
	logic [SW-1:0]         saved_dec;

	dfs_alu #(.W(W)) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	assign alu_sat   = alu_borrow ? '0 : alu_res;
	assign saved_dec = saved_q - SW'(1);

	dfs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(STACK_DEPTH)) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (cnt_q[EAW-1:0]),
		.wdata (elem_q),
		.raddr (alu_res[EAW-1:0]),
		.rdata (e_rdata)
	);

	dfs_ram #(.WIDTH(2 * CW), .DEPTH(FRAME_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (saved_q[FAW-1:0]),
		.wdata ({size_q, bot_q}),
		.raddr (saved_dec[FAW-1:0]),
		.rdata (f_rdata)
	);

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_AVAIL, S_FIN: begin
				alu_a = W'(size_q);
				alu_b = W'(bot_q);
			end
			S_OP: begin
				case (kind_q)
					KIND_PUSH: begin
						alu_a = W'(cnt_q);
						alu_b = W'(STACK_DEPTH);
					end
					KIND_POP, KIND_TOP: begin
						alu_a = W'(cnt_q);
						alu_b = empty_q ? W'(bot_q) : W'(1);
					end
					KIND_BOTTOM, KIND_POP_BOTTOM: begin
						alu_a = W'(cnt_q);
						alu_b = empty_q ? W'(bot_q) : W'(size_q);
					end
					KIND_ENTER: begin
						alu_a = W'(saved_q);
						alu_b = W'(FRAME_DEPTH);
					end
					default: begin
					end
				endcase
			end
			S_BADDR: begin
				alu_op = ALU_ADD;
				alu_a  = tmp_q;
				alu_b  = W'(bot_q);
			end
			S_LEAVE: begin
				alu_a = W'(cnt_q);
				alu_b = W'(size_q);
			end
			S_DCMP: begin
				alu_a = avail_q;
				alu_b = num_q;
			end
			S_DSUB: begin
				alu_a = num_q;
				alu_b = avail_q;
			end
			S_DDROP: begin
				alu_a = W'(cnt_q);
				alu_b = num_q;
			end
			S_DSIZE: begin
				alu_a = W'(size_q);
				alu_b = num_q;
			end
			default: begin
			end
		endcase
	end

	assign e_we = (state_q == S_OP) && (kind_q == KIND_PUSH) && alu_borrow;
	assign f_we = (state_q == S_OP) && (kind_q == KIND_ENTER) && !empty_q && alu_borrow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= KIND_PUSH;
			status_q <= STAT_OK;
			elem_q   <= '0;
			eout_q   <= '0;
			found_q  <= 1'b0;
			num_q    <= '0;
			avail_q  <= '0;
			tmp_q    <= '0;
			empty_q  <= 1'b0;
			skip_q   <= 1'b0;
			cnt_q    <= '0;
			size_q   <= '0;
			bot_q    <= '0;
			saved_q  <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != S_FIN)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q   <= kind_t'(s_tuser);
						elem_q   <= ELEM_WIDTH'(s_tdata[ELEM_W-1:0]);
						num_q    <= W'(s_tdata[ELEM_W+COUNT_W-1:ELEM_W]);
						status_q <= STAT_OK;
						found_q  <= 1'b0;
						eout_q   <= '0;
						state_q  <= S_AVAIL;
					end
				end
				S_AVAIL: begin
					avail_q <= alu_sat;
					empty_q <= alu_borrow || (alu_res == '0);
					state_q <= (kind_q == KIND_DISCARD) ? S_DCMP : S_OP;
				end
				S_OP: begin
					case (kind_q)
						KIND_PUSH: begin
							state_q <= S_FIN;
							if (!alu_borrow) begin
								status_q <= STAT_FULL;
							end else begin
								cnt_q  <= cnt_q + CW'(1);
								size_q <= size_q + CW'(1);
							end
						end
						KIND_POP, KIND_TOP: begin
							if (empty_q) begin
								cnt_q   <= CW'(alu_sat);
								size_q  <= '0;
								bot_q   <= '0;
								state_q <= S_FIN;
							end else begin
								found_q <= 1'b1;
								state_q <= S_RD;
								if (kind_q == KIND_POP) begin
									cnt_q  <= CW'(alu_res);
									size_q <= size_q - CW'(1);
								end
							end
						end
						KIND_BOTTOM, KIND_POP_BOTTOM: begin
							if (empty_q) begin
								state_q <= S_FIN;
								if (kind_q == KIND_BOTTOM) begin
									cnt_q  <= CW'(alu_sat);
									size_q <= '0;
									bot_q  <= '0;
								end else begin
									status_q <= STAT_EMPTY;
								end
							end else begin
								found_q <= 1'b1;
								tmp_q   <= alu_res;
								skip_q  <= alu_borrow;
								state_q <= S_BADDR;
							end
						end
						KIND_ENTER: begin
							state_q <= S_FIN;
							if (empty_q) begin
								status_q <= STAT_EMPTY;
							end else if (!alu_borrow) begin
								status_q <= STAT_FULL;
							end else begin
								saved_q <= saved_q + SW'(1);
								size_q  <= '0;
								bot_q   <= '0;
							end
						end
						KIND_LEAVE: begin
							if (saved_q == '0) begin
								status_q <= STAT_NOFRAME;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_LEAVE;
							end
						end
						KIND_CLEAR: begin
							cnt_q   <= '0;
							saved_q <= '0;
							size_q  <= '0;
							bot_q   <= '0;
							state_q <= S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_BADDR: begin
					if (kind_q == KIND_POP_BOTTOM) begin
						bot_q <= bot_q + CW'(1);
					end
					state_q <= skip_q ? S_FIN : S_RD;
				end
				S_RD: begin
					eout_q  <= e_rdata;
					state_q <= S_FIN;
				end
				S_LEAVE: begin
					cnt_q   <= CW'(alu_sat);
					saved_q <= saved_dec;
					state_q <= S_LVRD;
				end
				S_LVRD: begin
					size_q  <= f_rdata[2*CW-1:CW];
					bot_q   <= f_rdata[CW-1:0];
					state_q <= (kind_q == KIND_DISCARD) ? S_AVAIL : S_FIN;
				end
				S_DCMP: begin
					if (!alu_borrow) begin
						state_q <= S_DDROP;
					end else if (saved_q == '0) begin
						status_q <= STAT_NOFRAME;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_DSUB;
					end
				end
				S_DSUB: begin
					num_q   <= alu_res;
					state_q <= S_LEAVE;
				end
				S_DDROP: begin
					cnt_q   <= CW'(alu_sat);
					state_q <= S_DSIZE;
				end
				S_DSIZE: begin
					size_q  <= CW'(alu_res);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {{PAD{1'b0}}, ITEMS_W'(cnt_q), ITEMS_W'(alu_sat),
							SAVED_W'(saved_q), status_q, ELEM_W'(eout_q)};
						m_tuser  <= found_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/dfs_chk.sv =====
module dfs_chk
	import dfs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [M_USER_W-1:0] m_tuser
);

	localparam int STAT_LO = ELEM_W;
	localparam int SAVE_LO = ELEM_W + STATUS_W;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an op is running");

	a_nofound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[ELEM_W-1:0] == '0)
		else $error("element returned without found");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[STAT_LO+STATUS_W-1:STAT_LO] == STAT_OK)
		else $error("found with bad status");

	a_noframe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STAT_LO+STATUS_W-1:STAT_LO] == STAT_NOFRAME
		|-> m_tdata[SAVE_LO+SAVED_W-1:SAVE_LO] == '0)
		else $error("no-frame status with frames saved");

endmodule

bind dfs_frame_stack_core dfs_chk u_dfs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
